FILE: sv/jsfr_pkg.sv
// ----------------------------------------------------------------------------
// JSON object stream framer package
// Sizes, character codes and shared types for the framer.
// ----------------------------------------------------------------------------
`default_nettype none

package jsfr_pkg;

    localparam int MESSAGE_CAPACITY = 512;
    localparam int LEVEL_BITS       = 8;

    localparam int CNT_W    = $clog2(MESSAGE_CAPACITY);
    localparam int OFFSET_W = 9;
    localparam int POS_W    = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

    localparam logic [CNT_W-1:0]      OFFSET_LIMIT = CNT_W'(MESSAGE_CAPACITY - 1);
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX    = {LEVEL_BITS{1'b1}};

    localparam logic [7:0] CH_NUL           = 8'h00;
    localparam logic [7:0] CH_OPEN_BRACE    = 8'h7B;
    localparam logic [7:0] CH_OPEN_BRACKET  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_BRACE   = 8'h7D;
    localparam logic [7:0] CH_CLOSE_BRACKET = 8'h5D;
    localparam logic [7:0] CH_QUOTE         = 8'h22;
    localparam logic [7:0] CH_BACKSLASH     = 8'h5C;

    typedef struct packed {
        logic                  in_message;
        logic                  in_quoted;
        logic                  escape_pending;
        logic [LEVEL_BITS-1:0] nest_level;
        logic [CNT_W-1:0]      stored_count;
        logic                  overflow_seen;
    } t_frame_state;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic                is_first;
        logic                is_last;
        logic [OFFSET_W-1:0] byte_offset;
        logic                overflowed;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/jsfr_step.sv
// ----------------------------------------------------------------------------
// JSON object stream framer step
// Holds the framing state and turns one accepted byte into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module jsfr_step (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data_byte,
    output logic                   o_res_valid,
    output jsfr_pkg::t_result      o_res
);

    jsfr_pkg::t_frame_state r_state;
    jsfr_pkg::t_frame_state n_state;

    always_comb begin
        logic [jsfr_pkg::CNT_W-1:0] pos;
        logic [jsfr_pkg::POS_W-1:0] pos_ext;
        logic                       first;
        logic                       last;
        logic                       emit;

        n_state = r_state;
        pos     = '0;
        first   = 1'b0;
        last    = 1'b0;
        emit    = 1'b0;

        if (i_data_byte == jsfr_pkg::CH_NUL) begin
            emit = 1'b0;
        end else if (!r_state.in_message) begin
            if (i_data_byte == jsfr_pkg::CH_OPEN_BRACE) begin
                // A fresh message always starts at offset zero, count one.
                emit                   = 1'b1;
                first                  = 1'b1;
                n_state.in_message     = 1'b1;
                n_state.in_quoted      = 1'b0;
                n_state.escape_pending = 1'b0;
                n_state.nest_level     = jsfr_pkg::LEVEL_BITS'(1);
                n_state.stored_count   = jsfr_pkg::CNT_W'(1);
                n_state.overflow_seen  = 1'b0;
            end
        end else begin
            emit = 1'b1;
            if (r_state.stored_count < jsfr_pkg::OFFSET_LIMIT) begin
                pos                  = r_state.stored_count;
                n_state.stored_count = r_state.stored_count + jsfr_pkg::CNT_W'(1);
            end else begin
                pos                   = jsfr_pkg::OFFSET_LIMIT;
                n_state.overflow_seen = 1'b1;
            end

            if (r_state.in_quoted) begin
                if (r_state.escape_pending) begin
                    n_state.escape_pending = 1'b0;
                end else if (i_data_byte == jsfr_pkg::CH_BACKSLASH) begin
                    n_state.escape_pending = 1'b1;
                end else if (i_data_byte == jsfr_pkg::CH_QUOTE) begin
                    n_state.in_quoted = 1'b0;
                end
            end else if (i_data_byte == jsfr_pkg::CH_QUOTE) begin
                n_state.in_quoted = 1'b1;
            end else if (i_data_byte == jsfr_pkg::CH_OPEN_BRACE ||
                         i_data_byte == jsfr_pkg::CH_OPEN_BRACKET) begin
                if (r_state.nest_level < jsfr_pkg::LEVEL_MAX) begin
                    n_state.nest_level = r_state.nest_level + jsfr_pkg::LEVEL_BITS'(1);
                end
            end else if (i_data_byte == jsfr_pkg::CH_CLOSE_BRACE ||
                         i_data_byte == jsfr_pkg::CH_CLOSE_BRACKET) begin
                if (r_state.nest_level != '0) begin
                    n_state.nest_level = r_state.nest_level - jsfr_pkg::LEVEL_BITS'(1);
                end
                last = (n_state.nest_level == '0);
            end
        end

        pos_ext = jsfr_pkg::POS_W'(pos);

        o_res_valid       = i_accept && emit;
        o_res.out_byte    = i_data_byte;
        o_res.is_first    = first;
        o_res.is_last     = last;
        o_res.byte_offset = pos_ext[jsfr_pkg::OFFSET_W-1:0];
        o_res.overflowed  = n_state.overflow_seen;

        // The closing byte reports the flag first, then the frame is cleared.
        if (last) begin
            n_state = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: sv/jsfr_out_q.sv
// ----------------------------------------------------------------------------
// JSON object stream framer output queue
// Two-entry result queue that lets input keep flowing while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module jsfr_out_q (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire jsfr_pkg::t_result i_res,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output jsfr_pkg::t_result      o_res,
    output logic [1:0]             o_count
);

    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    jsfr_pkg::t_result r_d0;
    jsfr_pkg::t_result r_d1;
    jsfr_pkg::t_result n_d0;
    jsfr_pkg::t_result n_d1;
    logic              pop;

    assign pop     = (r_cnt != 2'd0) && !i_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_res   = r_d0;
    assign o_count = r_cnt;

    always_comb begin
        n_cnt = r_cnt;
        n_d0  = r_d0;
        n_d1  = r_d1;
        case ({i_push, pop})
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_d0 = i_res;
                end else begin
                    n_d0 = r_d1;
                    n_d1 = i_res;
                end
            end
            2'b01: begin
                n_d0  = r_d1;
                n_cnt = r_cnt - 2'd1;
            end
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_d0 = i_res;
                end else begin
                    n_d1 = i_res;
                end
                n_cnt = r_cnt + 2'd1;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

endmodule

`default_nettype wire

FILE: sv/json_object_stream_framer_unit.sv
// ----------------------------------------------------------------------------
// JSON object stream framer
// Cuts brace-delimited JSON objects out of a byte stream, tagging each byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_data_byte. One byte is taken per
//   cycle whenever o_stall is low. Zero bytes and bytes outside an object
//   are consumed but produce no transfer.
//   Output channel: o_valid / i_stall with the per-byte fields. Each object
//   byte comes out with its offset, first/last marks and the overflow flag.
//   Each result is registered in the result queue before it shows on o_valid.
//   Throughput is one byte per cycle while o_stall is low, set by the state
//   update feeding the result queue.
//   A two-entry result queue sits between the sides; while i_stall is high
//   the queue fills and o_stall rises once both entries are held. A stalled
//   result does not change.
//   Reset (i_rst_n low, synchronous) empties the queue and returns the
//   framer to searching for an opening brace.
// ----------------------------------------------------------------------------
`default_nettype none

module json_object_stream_framer_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [7:0]                        i_data_byte,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [7:0]                             o_out_byte,
    output logic                                   o_is_first,
    output logic                                   o_is_last,
    output logic [jsfr_pkg::OFFSET_W-1:0]          o_byte_offset,
    output logic                                   o_overflowed
);

    logic              accept;
    logic              res_valid;
    logic              q_full;
    logic [1:0]        q_count;
    jsfr_pkg::t_result res;
    jsfr_pkg::t_result q_res;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    jsfr_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    jsfr_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (q_res),
        .o_count (q_count)
    );

    assign o_out_byte    = q_res.out_byte;
    assign o_is_first    = q_res.is_first;
    assign o_is_last     = q_res.is_last;
    assign o_byte_offset = q_res.byte_offset;
    assign o_overflowed  = q_res.overflowed;

`ifndef SYNTHESIS
    a_first_is_brace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_first) |->
            (o_out_byte == jsfr_pkg::CH_OPEN_BRACE && o_byte_offset == '0 && !o_overflowed))
        else $error("first byte of an object is not an opening brace at offset zero");

    a_last_is_closer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last) |->
            (o_out_byte == jsfr_pkg::CH_CLOSE_BRACE ||
             o_out_byte == jsfr_pkg::CH_CLOSE_BRACKET))
        else $error("last byte of an object is not a closing brace or bracket");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count != 2'd3) && (q_full == (q_count == 2'd2)))
        else $error("result queue count out of range");

    a_full_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(q_full) && q_full) |-> $past(i_stall))
        else $error("result queue filled while the sink was taking transfers");
`endif

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// JSON object stream framer testbench
// Streams byte sequences into the framer. These include hand-picked cases,
// oversized objects, over-deep nesting and random JSON-like objects mixed with
// noise. An in-bench model predicts every tagged byte, and each output transfer
// is checked against that prediction. The random tests run under several
// idle and stall patterns on both channels.
// ----------------------------------------------------------------------------

module testbench;

    localparam int          IDLE_LIMIT = 2000;
    localparam logic [7:0]  CH_COLON   = 8'h3A;
    localparam logic [jsfr_pkg::LEVEL_BITS-1:0] LEVEL_TOP = '1;

    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic [7:0]                    i_data_byte = 8'h00;
    logic                          i_stall     = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic [7:0]                    o_out_byte;
    logic                          o_is_first;
    logic                          o_is_last;
    logic [jsfr_pkg::OFFSET_W-1:0] o_byte_offset;
    logic                          o_overflowed;

    json_object_stream_framer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_is_first    (o_is_first),
        .o_is_last     (o_is_last),
        .o_byte_offset (o_byte_offset),
        .o_overflowed  (o_overflowed)
    );

    // Framer state as the bench sees it.
    bit                              fr_in_msg;
    bit                              fr_quoted;
    bit                              fr_escape;
    logic [jsfr_pkg::LEVEL_BITS-1:0] fr_level;
    int unsigned                     fr_count;
    bit                              fr_ovf;

    jsfr_pkg::t_result tagged_bytes_due[$];
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned bytes_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned objects_ended = 0;
    int unsigned capped_bytes  = 0;
    int unsigned errors        = 0;
    int unsigned quiet_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic void clear_frame_state();
        fr_in_msg = 1'b0;
        fr_quoted = 1'b0;
        fr_escape = 1'b0;
        fr_level  = '0;
        fr_count  = 0;
        fr_ovf    = 1'b0;
    endfunction

    // Tags one byte; returns 0 when the byte produces no output.
    function automatic bit tag_byte(input logic [7:0] b, output jsfr_pkg::t_result r);
        int unsigned pos;
        bit          last;
        r    = '0;
        last = 1'b0;
        if (b == jsfr_pkg::CH_NUL) return 1'b0;
        if (!fr_in_msg) begin
            if (b != jsfr_pkg::CH_OPEN_BRACE) return 1'b0;
            fr_count   = 0;
            fr_ovf     = 1'b0;
            fr_in_msg  = 1'b1;
            fr_quoted  = 1'b0;
            fr_escape  = 1'b0;
            fr_level   = jsfr_pkg::LEVEL_BITS'(1);
            r.is_first = 1'b1;
        end else if (fr_quoted) begin
            if (fr_escape) fr_escape = 1'b0;
            else if (b == jsfr_pkg::CH_BACKSLASH) fr_escape = 1'b1;
            else if (b == jsfr_pkg::CH_QUOTE) fr_quoted = 1'b0;
        end else if (b == jsfr_pkg::CH_QUOTE) begin
            fr_quoted = 1'b1;
        end else if (b == jsfr_pkg::CH_OPEN_BRACE || b == jsfr_pkg::CH_OPEN_BRACKET) begin
            if (fr_level != LEVEL_TOP) fr_level = fr_level + jsfr_pkg::LEVEL_BITS'(1);
        end else if (b == jsfr_pkg::CH_CLOSE_BRACE || b == jsfr_pkg::CH_CLOSE_BRACKET) begin
            if (fr_level != '0) fr_level = fr_level - jsfr_pkg::LEVEL_BITS'(1);
            if (fr_level == '0) last = 1'b1;
        end
        // The last capture slot is held back; later bytes all land on it.
        if (fr_count < jsfr_pkg::MESSAGE_CAPACITY - 1) begin
            pos      = fr_count;
            fr_count = fr_count + 1;
        end else begin
            pos    = jsfr_pkg::MESSAGE_CAPACITY - 1;
            fr_ovf = 1'b1;
        end
        r.out_byte    = b;
        r.is_last     = last;
        r.byte_offset = jsfr_pkg::OFFSET_W'(pos);
        r.overflowed  = fr_ovf;
        if (last) clear_frame_state();
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        errors++;
        $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                 $realtime, results_seen, what, want, got);
    endtask

    always @(posedge i_clk) begin : result_monitor
        jsfr_pkg::t_result observed;
        jsfr_pkg::t_result want;
        jsfr_pkg::t_result predicted;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                observed.out_byte    = o_out_byte;
                observed.is_first    = o_is_first;
                observed.is_last     = o_is_last;
                observed.byte_offset = o_byte_offset;
                observed.overflowed  = o_overflowed;
                if (tagged_bytes_due.size() == 0) begin
                    report_mismatch("unexpected transfer, byte", 0, observed.out_byte);
                end else begin
                    want = tagged_bytes_due.pop_front();
                    if (observed.out_byte !== want.out_byte)
                        report_mismatch("out_byte", want.out_byte, observed.out_byte);
                    if (observed.is_first !== want.is_first)
                        report_mismatch("is_first", want.is_first, observed.is_first);
                    if (observed.is_last !== want.is_last)
                        report_mismatch("is_last", want.is_last, observed.is_last);
                    if (observed.byte_offset !== want.byte_offset)
                        report_mismatch("byte_offset", want.byte_offset,
                                        observed.byte_offset);
                    if (observed.overflowed !== want.overflowed)
                        report_mismatch("overflowed", want.overflowed,
                                        observed.overflowed);
                    if (want.is_last) objects_ended++;
                    if (want.overflowed) capped_bytes++;
                end
                results_seen++;
            end
            if (i_valid && !o_stall) begin
                if (tag_byte(i_data_byte, predicted)) tagged_bytes_due.push_back(predicted);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == IDLE_LIMIT) begin
                $display("No transfer for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, tagged_bytes_due.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid     <= 1'b0;
            i_data_byte <= 8'($urandom_range(255));
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[k]) send_byte(s[k]);
    endtask

    // A random byte that never changes the framing.
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == jsfr_pkg::CH_QUOTE || c == jsfr_pkg::CH_BACKSLASH ||
            c == jsfr_pkg::CH_OPEN_BRACE || c == jsfr_pkg::CH_OPEN_BRACKET ||
            c == jsfr_pkg::CH_CLOSE_BRACE || c == jsfr_pkg::CH_CLOSE_BRACKET)
            c = CH_COLON;
        return c;
    endfunction

    function automatic logic [7:0] any_closer();
        return $urandom_range(1) ? jsfr_pkg::CH_CLOSE_BRACE : jsfr_pkg::CH_CLOSE_BRACKET;
    endfunction

    task automatic test_directed();
        // Zero bytes and junk outside an object are dropped, a stray closer too.
        send_byte(jsfr_pkg::CH_NUL);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_text("x}");
        // Escaped quote and a brace inside a string, then a zero byte inside.
        send_text("{\"k\\\"}\":[");
        send_byte(jsfr_pkg::CH_NUL);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("]}");
        send_text("{}");
        // Escaped backslash must not swallow the closing quote.
        send_text("{\"\\\\\"}");
    endtask

    task automatic test_capture_limit();
        send_byte(jsfr_pkg::CH_OPEN_BRACE);
        repeat (jsfr_pkg::MESSAGE_CAPACITY + 8) send_byte(plain_byte());
        send_byte(jsfr_pkg::CH_CLOSE_BRACE);
        // The next object must start clean.
        send_text("{\"a\":1}");
    endtask

    task automatic test_nesting_limit();
        // The level stops at its top, so fewer closers end the object.
        send_byte(jsfr_pkg::CH_OPEN_BRACE);
        repeat ((1 << jsfr_pkg::LEVEL_BITS) + 4) send_byte(jsfr_pkg::CH_OPEN_BRACKET);
        repeat ((1 << jsfr_pkg::LEVEL_BITS) - 1) send_byte(jsfr_pkg::CH_CLOSE_BRACKET);
        send_byte(jsfr_pkg::CH_CLOSE_BRACE);
        send_byte(jsfr_pkg::CH_CLOSE_BRACKET);
    endtask

    task automatic test_random_frames(input int unsigned n_bytes,
                                      input int unsigned idle_pct,
                                      input int unsigned hold_pct);
        int unsigned stop_at;
        int unsigned pick;
        int          depth;
        logic [7:0]  c;
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        stop_at       = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                // Noise, rich in quotes and closers so a broken object can end.
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(5))
                        0: send_byte(jsfr_pkg::CH_QUOTE);
                        1: send_byte(any_closer());
                        2: send_byte(jsfr_pkg::CH_NUL);
                        default: send_byte(8'($urandom_range(255)));
                    endcase
                end
            end else if (pick < 25) begin
                send_byte(jsfr_pkg::CH_OPEN_BRACE);
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(jsfr_pkg::CH_OPEN_BRACE);
                depth = 1;
                repeat ($urandom_range(1, 24)) begin
                    pick = $urandom_range(99);
                    if (pick < 25) begin
                        send_byte(jsfr_pkg::CH_QUOTE);
                        repeat ($urandom_range(0, 6)) begin
                            c = 8'($urandom_range(255));
                            if (c == jsfr_pkg::CH_QUOTE || c == jsfr_pkg::CH_BACKSLASH ||
                                $urandom_range(7) == 0)
                                send_byte(jsfr_pkg::CH_BACKSLASH);
                            send_byte(c);
                        end
                        send_byte(jsfr_pkg::CH_QUOTE);
                    end else if (pick < 45 && depth < 8) begin
                        send_byte($urandom_range(1) ? jsfr_pkg::CH_OPEN_BRACE
                                                    : jsfr_pkg::CH_OPEN_BRACKET);
                        depth++;
                    end else if (pick < 60 && depth > 1) begin
                        send_byte(any_closer());
                        depth--;
                    end else begin
                        send_byte(plain_byte());
                    end
                end
                repeat (depth) send_byte(any_closer());
            end
        end
    endtask

    initial begin
        clear_frame_state();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_capture_limit();
        test_nesting_limit();
        test_random_frames(80, 0, 0);
        test_random_frames(80, 52, 0);
        test_random_frames(80, 0, 52);
        test_random_frames(80, 21, 21);

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (tagged_bytes_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tagged_bytes_due.size() != 0)
            report_mismatch("results left over, count", 0, tagged_bytes_due.size());

        $display("Streamed %0d bytes over four traffic patterns; %0d tagged bytes checked.",
                 bytes_sent, results_seen);
        $display("Objects closed: %0d, bytes past capture limit: %0d, mismatches: %0d.",
                 objects_ended, capped_bytes, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
